// ----- sv/assert_macros.svh -----
// Assertion macros shared by the valve sequencer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VTTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vtts assertion failed (same cycle)");
`define VTTS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vtts assertion failed (next cycle)");
`else
`define VTTS_ASSERT_IMP(label, clk, rst, ante, cons)
`define VTTS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/vtts_pkg.sv -----
`timescale 1ns / 1ps
// Package for the valve timed toggle sequencer: payload structs, request codes,
// controller state type and the command/status structs. No dependencies.
package vtts_pkg;

   localparam int QUEUE_DEPTH_DEF = 512;
   localparam int CHANNELS_DEF    = 7;
   localparam int VALVE_W         = 7;

   localparam logic [VALVE_W-1:0] EMERGENCY_PATTERN = 7'h10;

   localparam logic [2:0] OP_LOAD      = 3'd0;
   localparam logic [2:0] OP_START     = 3'd1;
   localparam logic [2:0] OP_TICK      = 3'd2;
   localparam logic [2:0] OP_SET       = 3'd3;
   localparam logic [2:0] OP_EMERGENCY = 3'd4;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [2:0]         channel;
      logic [8:0]         slot;
      logic [15:0]        toggle_time;
      logic [31:0]        now_ms;
      logic [VALVE_W-1:0] valve_pattern;
   } vtts_req_type;

   typedef struct packed {
      logic [VALVE_W-1:0] valve_bits;
      logic               running;
      logic               spark_on;
      logic               done_res;
   } vtts_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_EMIT
   } vtts_state_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic scan_begin;
      logic scan_issue;
      logic scan_finish;
      logic emit;
   } vtts_cmd_type;

   typedef struct packed {
      logic tick_run;
      logic issue_last;
      logic out_free;
   } vtts_status_type;

endpackage

// ----- sv/vtts_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the valve sequencer.
// Depends on vtts_pkg; drives the datapath through the command struct.
module vtts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  vtts_pkg::vtts_status_type status,
   output vtts_pkg::vtts_cmd_type    cmd
);

   vtts_pkg::vtts_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vtts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vtts_pkg::ST_IDLE: begin
            if (req_valid) state_in = vtts_pkg::ST_DECODE;
         end
         vtts_pkg::ST_DECODE: begin
            state_in = status.tick_run ? vtts_pkg::ST_SCAN : vtts_pkg::ST_EMIT;
         end
         vtts_pkg::ST_SCAN: begin
            if (status.issue_last) state_in = vtts_pkg::ST_DRAIN;
         end
         vtts_pkg::ST_DRAIN:  state_in = vtts_pkg::ST_FINISH;
         vtts_pkg::ST_FINISH: state_in = vtts_pkg::ST_EMIT;
         vtts_pkg::ST_EMIT: begin
            if (status.out_free) state_in = vtts_pkg::ST_IDLE;
         end
         default: state_in = vtts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         vtts_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         vtts_pkg::ST_DECODE: begin
            cmd.scan_begin = status.tick_run;
            cmd.apply      = !status.tick_run;
         end
         vtts_pkg::ST_SCAN:   cmd.scan_issue  = 1'b1;
         vtts_pkg::ST_DRAIN:  cmd.scan_issue  = 1'b0;
         vtts_pkg::ST_FINISH: cmd.scan_finish = 1'b1;
         vtts_pkg::ST_EMIT:   cmd.emit        = status.out_free;
         default:             cmd             = '0;
      endcase
   end

endmodule

// ----- sv/vtts_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the valve sequencer: toggle time memory, queue pointers, valve
// and run state, the channel scan pipeline and the result register. Uses vtts_pkg.
module vtts_datapath #(
   parameter int QUEUE_DEPTH = vtts_pkg::QUEUE_DEPTH_DEF,
   parameter int CHANNELS    = vtts_pkg::CHANNELS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vtts_pkg::vtts_req_type     req_data,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output vtts_pkg::vtts_rsp_type     rsp_data,
   input  vtts_pkg::vtts_cmd_type     cmd,
   output vtts_pkg::vtts_status_type  status
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = CH_W + SLOT_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int VW = vtts_pkg::VALVE_W;

   logic [15:0] time_store_ff [MEM_DEPTH];
   logic [15:0] head_rd_ff;
   logic [15:0] next_rd_ff;

   vtts_pkg::vtts_req_type item_ff;
   logic [LEN_W-1:0] rp_ff [CHANNELS];
   logic [LEN_W-1:0] rp_in [CHANNELS];
   logic [LEN_W-1:0] ql_ff [CHANNELS];
   logic [LEN_W-1:0] ql_in [CHANNELS];
   logic [VW-1:0]    valve_ff, valve_in;
   logic [31:0]      ref_ff, ref_in;
   logic             running_ff, running_in;
   logic             spark_ff, spark_in;
   logic             done_ff, done_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic             all_done_ff, all_done_in;

   logic [CH_W-1:0]  issue_idx_ff, issue_idx_in;
   logic             stage_vld_ff, stage_vld_in;
   logic [CH_W-1:0]  stage_ch_ff, stage_ch_in;
   logic [LEN_W-1:0] stage_rp_ff, stage_rp_in;
   logic             stage_v0_ff, stage_v0_in;
   logic             stage_v1_ff, stage_v1_in;

   logic             rsp_valid_ff, rsp_valid_in;
   vtts_pkg::vtts_rsp_type rsp_ff, rsp_in;

   logic [LEN_W-1:0] issue_rp;
   logic [LEN_W:0]   issue_rp1;
   logic [ADDR_W-1:0] rd_addr0, rd_addr1, wr_addr;
   logic             load_ok;
   logic             mem_we;
   logic [15:0]      h0, h_after;
   logic             adv;
   logic [VW-1:0]    toggle_mask;

   assign issue_rp  = rp_ff[issue_idx_ff];
   assign issue_rp1 = {1'b0, issue_rp} + (LEN_W + 1)'(1);
   assign rd_addr0  = {issue_idx_ff, issue_rp[SLOT_W-1:0]};
   assign rd_addr1  = {issue_idx_ff, issue_rp1[SLOT_W-1:0]};
   assign load_ok   = (int'(item_ff.channel) < CHANNELS) && (int'(item_ff.slot) < QUEUE_DEPTH);
   assign wr_addr   = {CH_W'(item_ff.channel), SLOT_W'(item_ff.slot)};
   assign mem_we    = cmd.apply && (item_ff.req_type == vtts_pkg::OP_LOAD) && load_ok;

   always_ff @(posedge clock) begin
      if (mem_we) time_store_ff[wr_addr] <= item_ff.toggle_time;
      head_rd_ff <= time_store_ff[rd_addr0];
      next_rd_ff <= time_store_ff[rd_addr1];
   end

   assign h0          = stage_v0_ff ? head_rd_ff : 16'h0;
   assign adv         = stage_vld_ff && (h0 != 16'h0) && ({16'h0, h0} < elapsed_ff);
   assign h_after     = adv ? (stage_v1_ff ? next_rd_ff : 16'h0) : h0;
   assign toggle_mask = VW'(1) << stage_ch_ff;

   always_comb begin
      rp_in        = rp_ff;
      ql_in        = ql_ff;
      valve_in     = valve_ff;
      ref_in       = ref_ff;
      running_in   = running_ff;
      spark_in     = spark_ff;
      done_in      = done_ff;
      elapsed_in   = elapsed_ff;
      all_done_in  = all_done_ff;
      issue_idx_in = issue_idx_ff;
      stage_vld_in = cmd.scan_issue;
      stage_ch_in  = issue_idx_ff;
      stage_rp_in  = issue_rp;
      stage_v0_in  = issue_rp < ql_ff[issue_idx_ff];
      stage_v1_in  = issue_rp1 < {1'b0, ql_ff[issue_idx_ff]};

      if (cmd.capture) done_in = 1'b0;

      if (cmd.apply) begin
         unique case (item_ff.req_type)
            vtts_pkg::OP_LOAD: begin
               if (load_ok) begin
                  ql_in[CH_W'(item_ff.channel)] = LEN_W'(item_ff.slot) + LEN_W'(1);
               end
            end
            vtts_pkg::OP_START: begin
               ref_in     = item_ff.now_ms;
               running_in = 1'b1;
               spark_in   = 1'b1;
               for (int c = 0; c < CHANNELS; c++) rp_in[c] = '0;
            end
            vtts_pkg::OP_SET: valve_in = item_ff.valve_pattern;
            vtts_pkg::OP_EMERGENCY: begin
               running_in = 1'b0;
               spark_in   = 1'b0;
               valve_in   = vtts_pkg::EMERGENCY_PATTERN;
            end
            default: valve_in = valve_ff;
         endcase
      end

      if (cmd.scan_begin) begin
         elapsed_in   = item_ff.now_ms - ref_ff;
         all_done_in  = 1'b1;
         issue_idx_in = '0;
      end

      if (cmd.scan_issue && !status.issue_last) begin
         issue_idx_in = issue_idx_ff + CH_W'(1);
      end

      if (adv) begin
         valve_in             = valve_ff ^ toggle_mask;
         rp_in[stage_ch_ff]   = stage_rp_ff + LEN_W'(1);
      end
      if (stage_vld_ff && (h_after != 16'h0)) all_done_in = 1'b0;

      if (cmd.scan_finish && all_done_ff) begin
         running_in = 1'b0;
         spark_in   = 1'b0;
         done_in    = 1'b1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.valve_bits = valve_ff;
         rsp_in.running    = running_ff;
         rsp_in.spark_on   = spark_ff;
         rsp_in.done_res   = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rp_ff[c] <= '0;
            ql_ff[c] <= '0;
         end
         valve_ff     <= '0;
         ref_ff       <= '0;
         running_ff   <= 1'b0;
         spark_ff     <= 1'b0;
         done_ff      <= 1'b0;
         all_done_ff  <= 1'b0;
         issue_idx_ff <= '0;
         stage_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         ql_ff        <= ql_in;
         valve_ff     <= valve_in;
         ref_ff       <= ref_in;
         running_ff   <= running_in;
         spark_ff     <= spark_in;
         done_ff      <= done_in;
         all_done_ff  <= all_done_in;
         issue_idx_ff <= issue_idx_in;
         stage_vld_ff <= stage_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
      elapsed_ff  <= elapsed_in;
      stage_ch_ff <= stage_ch_in;
      stage_rp_ff <= stage_rp_in;
      stage_v0_ff <= stage_v0_in;
      stage_v1_ff <= stage_v1_in;
      rsp_ff      <= rsp_in;
   end

   assign status.tick_run   = (item_ff.req_type == vtts_pkg::OP_TICK) && running_ff;
   assign status.issue_last = issue_idx_ff == CH_W'(CHANNELS - 1);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/valve_timed_toggle_sequencer.sv -----
`timescale 1ns / 1ps
// Valve timed toggle sequencer, top level: controller plus datapath.
// Load, start, set-valves and emergency requests are applied in DECODE and the result is
// registered in EMIT once the output is free; a tick while running reads one channel
// head per cycle from the dual-read toggle time memory. One request is in flight at a time.
// Reset clears pointers, lengths, valve and run state; the time memory is not cleared.
`include "assert_macros.svh"
module valve_timed_toggle_sequencer #(
   parameter int QUEUE_DEPTH = vtts_pkg::QUEUE_DEPTH_DEF,
   parameter int CHANNELS    = vtts_pkg::CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vtts_pkg::vtts_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vtts_pkg::vtts_rsp_type rsp_data
);

   vtts_pkg::vtts_cmd_type    cmd;
   vtts_pkg::vtts_status_type status;

   vtts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vtts_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CHANNELS    (CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   `VTTS_ASSERT_IMP(a_done_ends_run, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.running)
   `VTTS_ASSERT_IMP(a_spark_follows_run, clock, reset, rsp_valid, rsp_data.running == rsp_data.spark_on)
   `VTTS_ASSERT_NXT(a_busy_after_accept, clock, reset, cmd.capture, req_stall)
   `VTTS_ASSERT_NXT(a_emit_gives_result, clock, reset, cmd.emit, rsp_valid)

endmodule
